[rtl/modular_exponentiation_assert.svh]
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ME_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose right side is checked in the cycle after the left side holds.
`define ME_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[rtl/modexp_pkg.sv]
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;
    localparam int EXP_BITS = 63;
    localparam int MOD_BITS = 32;
    localparam int BASE_BITS = 63;
    localparam int EXP_CNT_BITS = $clog2(EXP_BITS + 1);
    localparam int MUL_CNT_BITS = $clog2(BASE_BITS + 1);
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
    localparam logic FUNC_POWER = 1'b0;
    localparam logic FUNC_INVERSE = 1'b1;

    typedef logic [MOD_BITS-1:0] mod_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mul_ctl_t;
endpackage

[rtl/modexp_if.sv]
// Valid/ready channel interfaces for requests and results.
interface modexp_req_if;
    logic valid;
    logic ready;
    logic func;
    logic [62:0] base_value;
    logic [62:0] exponent;
    modport source (output valid, output func, output base_value, output exponent, input ready);
    modport sink (input valid, input func, input base_value, input exponent, output ready);
endinterface

interface modexp_rsp_if;
    logic valid;
    logic ready;
    logic [31:0] result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

[rtl/modexp_mulmod.sv]
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
module modexp_mulmod (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [modexp_pkg::MOD_BITS-1:0]     m,
    input  logic [modexp_pkg::MOD_BITS-1:0]     a,
    input  logic [modexp_pkg::BASE_BITS-1:0]    b,
    input  logic [modexp_pkg::MUL_CNT_BITS-1:0] nbits,
    output modexp_pkg::mul_ctl_t                ctl,
    output logic [modexp_pkg::MOD_BITS-1:0]     p
);
    localparam int W = modexp_pkg::MOD_BITS;
    localparam int B = modexp_pkg::BASE_BITS;
    localparam int C = modexp_pkg::MUL_CNT_BITS;

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [C-1:0] cnt_reg, cnt_next;
    logic [B-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W+1:0] dbl, t1, add, t2;

    always_comb
    begin
        dbl = {1'b0, acc_reg, 1'b0};
        t1 = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        add = t1 + (b_reg[B-1] ? {2'b00, a} : '0);
        t2 = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = nbits;
            b_next = b;
            acc_next = '0;
        end
        else if (busy_reg)
        begin
            acc_next = t2[W-1:0];
            b_next = {b_reg[B-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == C'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        acc_reg <= acc_next;
    end

    assign ctl = '{start: start, busy: busy_reg, done: done_reg};
    assign p = acc_reg;
endmodule

[rtl/modular_exponentiation.sv]
// Modular exponentiation top level: square-and-multiply sequencer over a serial multiplier.
// Sequence: the base is first reduced modulo m, then each exponent bit takes a step state and
// up to two multiplies, a multiply by the base when the bit is set and then a squaring.
// The loop stops once the remaining exponent is zero, or at once when the modulus is 0 or 1.
// Throughput: one item at a time; the next beat is taken the cycle after the result is read.
// Reset: rst_n asynchronous active low clears control and loads modulus 1000000007.
`include "modular_exponentiation_assert.svh"
module modular_exponentiation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    modexp_req_if.sink          req,
    modexp_rsp_if.source        rsp
);
    localparam int W = modexp_pkg::MOD_BITS;
    localparam int E = modexp_pkg::EXP_BITS;
    localparam int B = modexp_pkg::BASE_BITS;
    localparam int EC = modexp_pkg::EXP_CNT_BITS;
    localparam int MC = modexp_pkg::MUL_CNT_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED = 3'd1;
    localparam logic [2:0] ST_MUL = 3'd2;
    localparam logic [2:0] ST_SQR = 3'd3;
    localparam logic [2:0] ST_STEP = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [W-1:0] mod_reg;
    logic [2:0] st_reg, st_next;
    logic [W-1:0] m_reg, acc_reg, base_reg;
    logic [E-1:0] e_reg;
    logic [EC-1:0] ecnt_reg;
    logic [B-1:0] bin_reg;
    logic [W-1:0] res_reg;
    logic rvalid_reg;
    logic mstart, wait_reg;
    logic [W-1:0] ma;
    logic [B-1:0] mb;
    logic [MC-1:0] mn;
    modexp_pkg::mul_ctl_t mctl;
    logic [W-1:0] mp;

    modexp_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .start(mstart), .m(m_reg), .a(ma), .b(mb),
        .nbits(mn), .ctl(mctl), .p(mp)
    );

    assign req.ready = (st_reg == ST_IDLE) && !rvalid_reg;
    assign rsp.valid = rvalid_reg;
    assign rsp.result = res_reg;

    always_comb
    begin
        mstart = 1'b0;
        ma = base_reg;
        mb = '0;
        mn = MC'(W);
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (req.valid && req.ready) st_next = ST_RED;
            ST_RED:
            begin
                ma = W'(1);
                mb = bin_reg;
                mn = MC'(B);
                mstart = !wait_reg;
                if (mctl.done) st_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (m_reg <= W'(1) || ecnt_reg == '0 || e_reg == '0) st_next = ST_OUT;
                else if (e_reg[0]) st_next = ST_MUL;
                else st_next = ST_SQR;
            end
            ST_MUL:
            begin
                ma = acc_reg;
                mb = {{(B-W){1'b0}}, base_reg};
                mb = mb << (B - W);
                mstart = !wait_reg;
                if (mctl.done) st_next = ST_SQR;
            end
            ST_SQR:
            begin
                mb = {base_reg, {(B-W){1'b0}}};
                mstart = !wait_reg;
                if (mctl.done) st_next = ST_STEP;
            end
            ST_OUT: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= modexp_pkg::MODULUS_RESET;
            st_reg <= ST_IDLE;
            rvalid_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) mod_reg <= cfg_wdata[W-1:0];
            st_reg <= st_next;
            if (mstart) wait_reg <= 1'b1;
            else if (mctl.done) wait_reg <= 1'b0;
            if (st_reg == ST_OUT) rvalid_reg <= 1'b1;
            else if (rsp.ready) rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                m_reg <= mod_reg;
                bin_reg <= req.base_value;
                acc_reg <= W'(1);
                if (req.func == modexp_pkg::FUNC_INVERSE)
                    e_reg <= E'(mod_reg - W'(2));
                else
                    e_reg <= req.exponent[E-1:0];
                ecnt_reg <= EC'(E);
            end
            ST_RED: if (mctl.done) base_reg <= mp;
            ST_MUL: if (mctl.done) acc_reg <= mp;
            ST_SQR:
            begin
                if (mctl.done)
                begin
                    base_reg <= mp;
                    e_reg <= e_reg >> 1;
                    ecnt_reg <= ecnt_reg - 1'b1;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0) ecnt_reg <= '0;
            end
            ST_OUT: res_reg <= (m_reg <= W'(1)) ? '0 : acc_reg;
            default: ;
        endcase
    end

    `ME_ASSERT_IMP(a_ready_idle, clk, rst_n, req.ready, st_reg == ST_IDLE, "ready outside idle")
    `ME_ASSERT_IMP(a_res_range, clk, rst_n, rsp.valid && m_reg > W'(1), rsp.result < m_reg, "result not reduced")
    `ME_ASSERT_NEXT(a_accept_red, clk, rst_n, req.valid && req.ready, st_reg == ST_RED, "no reduce after accept")
    `ME_ASSERT_IMP(a_mul_idle, clk, rst_n, st_reg == ST_IDLE, !mctl.busy, "multiplier busy in idle")
endmodule

[bench/tb_top.sv]
// Self-checking testbench for the modular exponentiation block.
module tb_top;
    localparam int LIMIT = 30000000;
    localparam int DRAIN = 6000;

    typedef struct {
        logic        func;
        logic [62:0] base_value;
        logic [62:0] exponent;
        logic        known;
        logic [31:0] result;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic [31:0] modulus;
    logic [31:0] residue_q[$];
    int          errors;
    int          cycles;
    int          rsp_stall;

    modexp_req_if req();
    modexp_rsp_if rsp();

    modular_exponentiation u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req.sink),
        .rsp(rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] pow_mod(logic [62:0] b, logic [62:0] e, logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        if (m == 0)
            return 32'd0;
        acc = 64'd1 % m;
        sq = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] predict_residue(logic f, logic [62:0] b, logic [62:0] e);
        if (modulus == 0)
            return 32'd0;
        if (f == modexp_pkg::FUNC_INVERSE)
            return (modulus >= 2) ? pow_mod(b, 63'(modulus - 2), modulus) : 32'd0;
        return pow_mod(b, e, modulus);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(0, 3);
    endfunction

    task automatic expect_residue(logic [31:0] value);
        residue_q = {residue_q, value};
    endtask

    task automatic send_beat(logic f, logic [62:0] b, logic [62:0] e);
        @(negedge clk);
        req.valid <= 1'b1;
        req.func <= f;
        req.base_value <= b;
        req.exponent <= e;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (residue_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_modulus(logic [31:0] value);
        wait_drained();
        repeat (20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        modulus = value;
    endtask

    function automatic logic [62:0] rand63();
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = v & 63'hFF;
            1: v = v & 63'hFFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic run_random(int count);
        logic [62:0] e;
        for (int i = 0; i < count; i++)
        begin
            repeat (gap_len()) @(negedge clk);
            e = rand63();
            if ($urandom_range(0, 3) != 0)
                e = e & 63'((64'd1 << $urandom_range(1, 16)) - 1);
            if ($urandom_range(0, 99) == 0)
                e = '1;
            send_beat(logic'($urandom_range(0, 1)), rand63(), e);
            expect_residue(predict_residue(req.func, req.base_value, req.exponent));
        end
    endtask

    // Scoreboard
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (residue_q.size() == 0)
            begin
                $error("unexpected beat: result=%0d", rsp.result);
                errors++;
            end
            else
            begin
                if (rsp.result !== residue_q[0])
                begin
                    $error("result: expected %0d actual %0d", residue_q[0], rsp.result);
                    errors++;
                end
                void'(residue_q.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall--;
        end
        else if (rsp.valid && $urandom_range(0, 3) == 0)
        begin
            rsp.ready <= 1'b0;
            rsp_stall = gap_len();
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("** modular_exponentiation: FAILED **");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        logic [31:0] want;
        logic [31:0] moduli[8];
        errors = 0;
        cycles = 0;
        rsp_stall = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = modexp_pkg::FUNC_POWER;
        req.base_value = '0;
        req.exponent = '0;
        rsp.ready = 1'b0;
        modulus = modexp_pkg::MODULUS_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        rows = '{
            '{modexp_pkg::FUNC_POWER, 63'd5, 63'd0, 1'b1, 32'd1},
            '{modexp_pkg::FUNC_POWER, 63'd0, 63'd0, 1'b1, 32'd1},
            '{modexp_pkg::FUNC_POWER, 63'd0, 63'd5, 1'b1, 32'd0},
            '{modexp_pkg::FUNC_POWER, 63'd2, 63'd10, 1'b1, 32'd1024},
            '{modexp_pkg::FUNC_POWER, 63'd1000000007, 63'd3, 1'b1, 32'd0},
            '{modexp_pkg::FUNC_POWER, '1, '1, 1'b0, 32'd0},
            '{modexp_pkg::FUNC_POWER, 63'd3, '1, 1'b0, 32'd0},
            '{modexp_pkg::FUNC_INVERSE, 63'd1, 63'd0, 1'b1, 32'd1},
            '{modexp_pkg::FUNC_INVERSE, 63'd2, '1, 1'b1, 32'd500000004},
            '{modexp_pkg::FUNC_INVERSE, 63'd0, 63'd0, 1'b1, 32'd0},
            '{modexp_pkg::FUNC_INVERSE, '1, 63'd7, 1'b0, 32'd0},
            '{modexp_pkg::FUNC_INVERSE, 63'h2AAA_AAAA_AAAA_AAAA, 63'd0, 1'b0, 32'd0}
        };
        foreach (rows[i])
        begin
            want = rows[i].known ? rows[i].result
                : predict_residue(rows[i].func, rows[i].base_value, rows[i].exponent);
            send_beat(rows[i].func, rows[i].base_value, rows[i].exponent);
            expect_residue(want);
        end

        // Small moduli: zero, one, two, and a composite
        write_modulus(32'd0);
        send_beat(modexp_pkg::FUNC_POWER, 63'd7, 63'd0);
        expect_residue(32'd0);
        send_beat(modexp_pkg::FUNC_INVERSE, 63'd7, 63'd3);
        expect_residue(32'd0);
        write_modulus(32'd1);
        send_beat(modexp_pkg::FUNC_POWER, 63'd7, 63'd0);
        expect_residue(32'd0);
        send_beat(modexp_pkg::FUNC_INVERSE, 63'd7, 63'd0);
        expect_residue(32'd0);
        write_modulus(32'd2);
        send_beat(modexp_pkg::FUNC_INVERSE, 63'd4, 63'd0);
        expect_residue(32'd1);
        send_beat(modexp_pkg::FUNC_POWER, 63'd3, 63'd9);
        expect_residue(32'd1);
        write_modulus(32'd15);
        send_beat(modexp_pkg::FUNC_INVERSE, 63'd2, 63'd0);
        expect_residue(32'd2);

        moduli = '{32'd1000000007, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd2,
                   32'd97, 32'h8000_0000, 32'd3, 32'd65521};
        foreach (moduli[i])
        begin
            write_modulus(moduli[i]);
            run_random(120);
            if (i == 3)
                wait_drained();
        end
        write_modulus($urandom);
        run_random(150);
        write_modulus(32'd0);
        run_random(20);
        write_modulus(32'd1);
        run_random(20);
        write_modulus($urandom_range(2, 1000));
        run_random(100);

        wait_drained();
        repeat (DRAIN) @(negedge clk);
        if (errors == 0)
            $display("** modular_exponentiation: PASSED **");
        else
            $display("** modular_exponentiation: FAILED **");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_if.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
bench/tb_top.sv
